@@ src/pbid_pkg.sv @@
// ----------------------------------------------------------------------------
// pbid_pkg: shared types and constants
// Word formats, codes and reset values for the PackBits image decoder.
// ----------------------------------------------------------------------------
package pbid_pkg;

    localparam int unsigned HDR_W  = 10;
    localparam int unsigned ROWB_W = 8;
    localparam int unsigned ROWS_W = 12;
    localparam int unsigned CFG_W  = 12;

    localparam logic [HDR_W-1:0]  HEADER_LENGTH_RST = 10'd512;
    localparam logic [ROWB_W-1:0] ROW_BYTES_RST     = 8'd72;
    localparam logic [ROWS_W-1:0] ROW_TOTAL_RST     = 12'd720;

    // code bytes below this introduce literals, others introduce repeats
    localparam logic [7:0] LITERAL_LIMIT = 8'd128;
    localparam logic [8:0] REPEAT_BASE   = 9'd257;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EOF   = 2'd1,
        KIND_START = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_EOF = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_HEADER_LENGTH = 2'd0,
        CFG_ROW_BYTES     = 2'd1,
        CFG_ROW_TOTAL     = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CODE    = 3'd1,
        PH_LITERAL = 3'd2,
        PH_REPEAT  = 3'd3,
        PH_IDLE    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] run_value;
        logic [7:0] run_count;
        logic       row_end;
        logic       image_end;
        logic [1:0] status;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

@@ src/pbid_core.sv @@
// ----------------------------------------------------------------------------
// pbid_core: decode state and per-byte logic
// Holds the configuration and decode counters, and turns each accepted input
// word into at most one result word (a run or a status) in the same cycle.
// ----------------------------------------------------------------------------
module pbid_core
    import pbid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                accept,
    input  in_word_t            word,
    output result_t             result
);

    logic [HDR_W-1:0]  header_length_reg;
    logic [ROWB_W-1:0] row_bytes_reg;
    logic [ROWS_W-1:0] row_total_reg;

    phase_t            phase_reg, phase_next;
    logic [HDR_W-1:0]  header_left_reg, header_left_next;
    logic [7:0]        literal_left_reg, literal_left_next;
    logic [7:0]        repeat_count_reg, repeat_count_next;
    logic [ROWB_W-1:0] row_done_reg, row_done_next;
    logic [ROWS_W-1:0] row_index_reg, row_index_next;

    logic [7:0]        b;
    logic              is_literal_code;
    logic [8:0]        code_n;
    logic [8:0]        room;
    logic              too_big;
    logic              take_code;
    logic [7:0]        run_cnt;
    logic [7:0]        done_sum;
    logic              row_hit;
    logic [ROWS_W-1:0] row_index_inc;
    logic              img_hit;
    logic [HDR_W-1:0]  header_dec;

    assign b               = word.data_byte;
    assign is_literal_code = b < LITERAL_LIMIT;
    assign code_n          = is_literal_code ? ({1'b0, b} + 9'd1) : (REPEAT_BASE - {1'b0, b});
    assign room            = (row_bytes_reg > row_done_reg)
                             ? ({1'b0, row_bytes_reg} - {1'b0, row_done_reg}) : 9'd0;
    assign too_big         = code_n > room;
    assign take_code       = (phase_reg == PH_CODE)
                             || ((phase_reg == PH_HEADER) && (header_left_reg == '0));
    assign run_cnt         = (phase_reg == PH_LITERAL) ? 8'd1 : repeat_count_reg;
    assign done_sum        = row_done_reg + run_cnt;
    assign row_hit         = done_sum == row_bytes_reg;
    assign row_index_inc   = row_index_reg + 1'b1;
    assign img_hit         = row_index_inc == row_total_reg;
    assign header_dec      = header_left_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg <= HEADER_LENGTH_RST;
            row_bytes_reg     <= ROW_BYTES_RST;
            row_total_reg     <= ROW_TOTAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_LENGTH: header_length_reg <= cfg_data[HDR_W-1:0];
                CFG_ROW_BYTES:     row_bytes_reg     <= cfg_data[ROWB_W-1:0];
                CFG_ROW_TOTAL:     row_total_reg     <= cfg_data[ROWS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_left_reg  <= HEADER_LENGTH_RST;
            literal_left_reg <= '0;
            repeat_count_reg <= '0;
            row_done_reg     <= '0;
            row_index_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_left_reg  <= header_left_next;
            literal_left_reg <= literal_left_next;
            repeat_count_reg <= repeat_count_next;
            row_done_reg     <= row_done_next;
            row_index_reg    <= row_index_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        header_left_next  = header_left_reg;
        literal_left_next = literal_left_reg;
        repeat_count_next = repeat_count_reg;
        row_done_next     = row_done_reg;
        row_index_next    = row_index_reg;

        if (accept)
        begin
            case (word.kind)
                KIND_START:
                begin
                    header_left_next  = header_length_reg;
                    phase_next        = (header_length_reg == '0) ? PH_CODE : PH_HEADER;
                    literal_left_next = '0;
                    repeat_count_next = '0;
                    row_done_next     = '0;
                    row_index_next    = '0;
                end
                KIND_EOF:
                begin
                    phase_next = PH_IDLE;
                end
                KIND_DATA:
                begin
                    if (take_code)
                    begin
                        if (too_big)
                            phase_next = PH_IDLE;
                        else if (is_literal_code)
                        begin
                            literal_left_next = code_n[7:0];
                            phase_next        = PH_LITERAL;
                        end
                        else
                        begin
                            repeat_count_next = code_n[7:0];
                            phase_next        = PH_REPEAT;
                        end
                    end
                    else if (phase_reg == PH_HEADER)
                    begin
                        header_left_next = header_dec;
                        if (header_dec == '0)
                            phase_next = PH_CODE;
                    end
                    else if ((phase_reg == PH_LITERAL) || (phase_reg == PH_REPEAT))
                    begin
                        if (phase_reg == PH_LITERAL)
                        begin
                            literal_left_next = literal_left_reg - 8'd1;
                            phase_next = (literal_left_next != '0) ? PH_LITERAL : PH_CODE;
                        end
                        else
                        begin
                            repeat_count_next = '0;
                            phase_next        = PH_CODE;
                        end
                        // advance the row position; the last row closes the image
                        if (row_hit)
                        begin
                            row_done_next  = '0;
                            row_index_next = row_index_inc;
                            if (img_hit)
                                phase_next = PH_IDLE;
                        end
                        else
                            row_done_next = done_sum;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word
    always_comb
    begin
        result.valid          = 1'b0;
        result.word.run_value = '0;
        result.word.run_count = '0;
        result.word.row_end   = 1'b0;
        result.word.image_end = 1'b0;
        result.word.status    = ST_OK;

        if (accept)
        begin
            case (word.kind)
                KIND_EOF:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        result.valid       = 1'b1;
                        result.word.status = ST_EOF;
                    end
                end
                KIND_DATA:
                begin
                    if (take_code)
                    begin
                        if (too_big)
                        begin
                            result.valid       = 1'b1;
                            result.word.status = ST_BAD;
                        end
                    end
                    else if ((phase_reg == PH_LITERAL) || (phase_reg == PH_REPEAT))
                    begin
                        result.valid          = 1'b1;
                        result.word.run_value = b;
                        result.word.run_count = run_cnt;
                        result.word.row_end   = row_hit;
                        result.word.image_end = row_hit && img_hit;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ src/pbid_out_buf.sv @@
// ----------------------------------------------------------------------------
// pbid_out_buf: result register with skid stage
// Holds the result word for the receiver and absorbs one more word while the
// receiver stalls, so the input side keeps moving.
// ----------------------------------------------------------------------------
module pbid_out_buf
    import pbid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   push,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t main_reg, main_next;
    out_word_t skid_reg, skid_next;
    logic      pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = push.word;
                skid_valid_next = push.valid;
            end
            else
            begin
                main_next       = push.word;
                main_valid_next = push.valid;
            end
        end
        else if (push.valid)
        begin
            // hold the output word, park the new one
            skid_next       = push.word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ src/packbits_image_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// packbits_image_decoder_unit: PackBits bitmap decoder
// Input channel: one file word per accept (data byte, end of file or start of
//   image), in_valid/in_stall. Output channel: one run word (value, count,
//   row end, image end, status), out_valid/out_stall.
// Configuration: cfg_valid/cfg_ready write port, always ready; index 0 is the
//   header length, 1 the row length in bytes, 2 the row count. Write only
//   while the block is idle; a new header length takes effect at the next
//   start word.
// Throughput: one input word per cycle while in_stall is low; all decode work
//   for a word is one pass through the core logic into the output register,
//   or into the skid stage while the receiver stalls.
// Stall: a skid stage behind the output register takes one more run while
//   the receiver stalls; in_stall rises only when that stage is occupied.
// Reset: configuration returns to header 512, row 72 bytes, 720 rows, and
//   the decoder starts in header skip; output is empty.
// ----------------------------------------------------------------------------
module packbits_image_decoder_unit
    import pbid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic    accept;
    logic    buf_full;
    result_t result;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    pbid_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (in_data),
        .result    (result)
    );

    pbid_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
